// ===== rtl/wbps_pkg.sv =====
`default_nettype none

package wbps_pkg;

	// Sizing
	localparam int MAX_KEY     = 64;
	localparam int OFFSET_BITS = 32;
	localparam int KEY_IDX_W   = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
	localparam int WIN_DEPTH   = 2 ** KEY_IDX_W;
	localparam int LEN_W       = $clog2(MAX_KEY + 1) > 0 ? $clog2(MAX_KEY + 1) : 1;

	// Fixed field widths
	localparam int KEYCFG_W = 7;
	localparam int INDEX_W  = 6;
	localparam int BYTE_W   = 8;
	localparam int OUT_W    = 32;

	// Input item kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_SCAN = 1'b1;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic scan_accept;
		logic load_accept;
		logic eval;
		logic issue;
		logic finish;
	} wbps_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic eligible;
		logic last_issue;
		logic match;
		logic out_blocked;
	} wbps_status_t;

	// Clamp the programmed key length to 1..MAX_KEY
	function automatic logic [LEN_W-1:0] used_length(input logic [KEYCFG_W-1:0] kl);
		logic [LEN_W-1:0] res;
		if (kl == '0) begin
			res = LEN_W'(1);
		end else if (32'(kl) > MAX_KEY) begin
			res = LEN_W'(MAX_KEY);
		end else begin
			res = LEN_W'(kl);
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/wildcard_byte_pattern_scanner_unit.sv =====
`default_nettype none

// Wildcard byte pattern scanner. Load items (kind 0) write one pattern entry,
// a byte or a wildcard. Scan items (kind 1) push one region byte and report
// the start offset of a match of the last key_length bytes; matches never
// overlap, and last_byte ends the region and restarts offsets at zero. A scan
// item that cannot yet start an allowed match goes from evaluation to finish;
// a tested one runs the compare loop, which walks one pattern entry per cycle
// through the single read port of the pattern store and of the byte window,
// then drains and finishes; no new item is taken before it finishes. A found
// offset waits in an output register while the next item is taken; a scan
// item that finds a match while that offset has not been taken yet holds in
// its last cycle until the transfer. key_length must be written only while
// the block is idle (not enforced by the block); 0 acts as 1, above 64 as 64.
module wildcard_byte_pattern_scanner_unit (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire                            kind,
	input  wire  [wbps_pkg::INDEX_W-1:0]   entry_index,
	input  wire  [wbps_pkg::BYTE_W-1:0]    entry_value,
	input  wire                            entry_wildcard,
	input  wire  [wbps_pkg::BYTE_W-1:0]    data_byte,
	input  wire                            last_byte,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [wbps_pkg::OUT_W-1:0]     match_offset,
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire  [wbps_pkg::KEYCFG_W-1:0]  key_length
);
	import wbps_pkg::*;

	wbps_cmd_t    cmd;
	wbps_status_t status;

	// Config transfers are always taken
	assign cfg_ready = 1'b1;

	wbps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.status   (status),
		.cmd      (cmd)
	);

	wbps_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_valid      (cfg_valid),
		.key_length     (key_length),
		.entry_index    (entry_index),
		.entry_value    (entry_value),
		.entry_wildcard (entry_wildcard),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.match_offset   (match_offset)
	);

endmodule

`default_nettype wire

// ===== rtl/wbps_ctrl.sv =====
`default_nettype none

module wbps_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire                   kind,
	input  wbps_pkg::wbps_status_t status,
	output wbps_pkg::wbps_cmd_t    cmd
);
	import wbps_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_ISSUE,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   xfer;

	assign in_ready = (state_q == ST_IDLE);
	assign xfer     = in_valid && in_ready;

	// Command decode
	always_comb begin
		cmd             = '0;
		cmd.scan_accept = xfer && (kind == KIND_SCAN);
		cmd.load_accept = xfer && (kind == KIND_LOAD);
		cmd.eval        = (state_q == ST_EVAL);
		cmd.issue       = (state_q == ST_ISSUE);
		cmd.finish      = (state_q == ST_FINISH) && !(status.match && status.out_blocked);
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (xfer && (kind == KIND_SCAN)) state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					state_q <= status.eligible ? ST_ISSUE : ST_FINISH;
				end
				ST_ISSUE: begin
					if (status.last_issue) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!(status.match && status.out_blocked)) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/wbps_datapath.sv =====
`default_nettype none

module wbps_datapath (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wbps_pkg::wbps_cmd_t                  cmd,
	output wbps_pkg::wbps_status_t               status,
	input  wire                                  cfg_valid,
	input  wire  [wbps_pkg::KEYCFG_W-1:0]        key_length,
	input  wire  [wbps_pkg::INDEX_W-1:0]         entry_index,
	input  wire  [wbps_pkg::BYTE_W-1:0]          entry_value,
	input  wire                                  entry_wildcard,
	input  wire  [wbps_pkg::BYTE_W-1:0]          data_byte,
	input  wire                                  last_byte,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic [wbps_pkg::OUT_W-1:0]           match_offset
);
	import wbps_pkg::*;

	logic [KEYCFG_W-1:0]    key_len_q;
	logic [LEN_W-1:0]       len;

	logic [BYTE_W:0]        pat_mem_q [MAX_KEY];
	logic [BYTE_W-1:0]      win_mem_q [WIN_DEPTH];
	logic [KEY_IDX_W-1:0]   wp_q;
	logic [KEY_IDX_W-1:0]   base_q;

	logic [OFFSET_BITS-1:0] pos_q;
	logic [OFFSET_BITS-1:0] nas_q;
	logic [OFFSET_BITS-1:0] start_q;
	logic                   last_q;
	logic                   elig_q;
	logic                   fail_q;

	logic [LEN_W-1:0]       rd_cnt_q;
	logic                   cmp_vld_s1;
	logic [BYTE_W:0]        pat_rd_s1;
	logic [BYTE_W-1:0]      win_rd_s1;

	logic [OFFSET_BITS:0]   pos_inc;
	logic [OFFSET_BITS:0]   start_full;
	logic [OFFSET_BITS-1:0] start;
	logic                   eligible;
	logic                   match;

	logic                   out_valid_q;
	logic [OUT_W-1:0]       match_offset_q;

	assign len = used_length(key_len_q);

	// Key length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q <= KEYCFG_W'(1);
		end else if (cfg_valid) begin
			key_len_q <= key_length;
		end
	end

	// Pattern store, written by load items
	always_ff @(posedge clk) begin
		if (cmd.load_accept && (32'(entry_index) < MAX_KEY)) begin
			pat_mem_q[KEY_IDX_W'(entry_index)] <= {entry_wildcard, entry_value};
		end
	end

	// Byte window as a circular buffer; newest byte sits just below wp_q
	always_ff @(posedge clk) begin
		if (cmd.scan_accept) begin
			win_mem_q[wp_q] <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
		end else if (cmd.scan_accept) begin
			wp_q <= wp_q + KEY_IDX_W'(1);
		end
	end

	// Window start and eligibility of the new window; the start is compared
	// at full width so a start one past the offset range still counts as late
	assign pos_inc    = {1'b0, pos_q} + (OFFSET_BITS + 1)'(1);
	assign start_full = pos_inc - (OFFSET_BITS + 1)'(len);
	assign start      = start_full[OFFSET_BITS-1:0];
	assign eligible   = (pos_inc >= (OFFSET_BITS + 1)'(len))
		&& (start_full >= {1'b0, nas_q});

	always_ff @(posedge clk) begin
		if (cmd.scan_accept) begin
			last_q <= last_byte;
		end
		if (cmd.eval) begin
			start_q <= start;
			base_q  <= wp_q - KEY_IDX_W'(len);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elig_q <= 1'b0;
		end else if (cmd.eval) begin
			elig_q <= eligible;
		end
	end

	// Compare loop: issue one entry per cycle, compare it in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			fail_q     <= 1'b0;
		end else begin
			cmp_vld_s1 <= cmd.issue;
			if (cmd.eval) begin
				rd_cnt_q <= '0;
				fail_q   <= 1'b0;
			end else begin
				if (cmd.issue) begin
					rd_cnt_q <= rd_cnt_q + LEN_W'(1);
				end
				if (cmp_vld_s1 && !pat_rd_s1[BYTE_W]
						&& (pat_rd_s1[BYTE_W-1:0] != win_rd_s1)) begin
					fail_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			pat_rd_s1 <= pat_mem_q[rd_cnt_q[KEY_IDX_W-1:0]];
			win_rd_s1 <= win_mem_q[base_q + rd_cnt_q[KEY_IDX_W-1:0]];
		end
	end

	assign match = elig_q && !fail_q;

	// Offsets, updated once the item's test is over
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			nas_q <= '0;
		end else if (cmd.finish) begin
			if (last_q) begin
				pos_q <= '0;
				nas_q <= '0;
			end else begin
				pos_q <= pos_inc[OFFSET_BITS-1:0];
				if (match) begin
					nas_q <= start_q + OFFSET_BITS'(len) + OFFSET_BITS'(1);
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish && match) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish && match) begin
			match_offset_q <= OUT_W'(start_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign match_offset = match_offset_q;

	always_comb begin
		status             = '0;
		status.eligible    = eligible;
		status.last_issue  = (rd_cnt_q == (len - LEN_W'(1)));
		status.match       = match;
		status.out_blocked = out_valid_q && !out_ready;
	end

endmodule

`default_nettype wire

// ===== sim/tb_wildcard_byte_pattern_scanner_unit.sv =====
`timescale 1ns / 100ps

module tb_wildcard_byte_pattern_scanner_unit;

	localparam int SETTLE_CYCLES = 100;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int HOLD_CYCLES   = 300;

	typedef enum logic [1:0] {OP_LOAD, OP_SCAN, OP_KEY} stim_op_t;

	// One stimulus step; typed rows carry their own expected match
	typedef struct packed {
		stim_op_t    op;
		logic [5:0]  idx;
		logic [7:0]  val;
		logic        wild;
		logic [7:0]  data;
		logic        lastb;
		logic [6:0]  key;
		logic        typed;
		logic        t_hit;
		logic [31:0] t_off;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        kind = wbps_pkg::KIND_LOAD;
	logic [5:0]  entry_index = '0;
	logic [7:0]  entry_value = '0;
	logic        entry_wildcard = 1'b0;
	logic [7:0]  data_byte = '0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] match_offset;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [6:0]  key_length = 7'd1;

	// Scanner state mirror
	logic [8:0]  mdl_pat [0:63];
	logic [7:0]  mdl_win [0:63];
	logic [31:0] mdl_pos = '0;
	logic [31:0] mdl_next = '0;
	logic [6:0]  mdl_key = 7'd1;

	logic [31:0] offsets_due [$];
	logic [31:0] want;
	int          errors = 0;
	int          items_sent = 0;
	int          cycle_count = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_left = 0;
	bit          hold_req = 1'b0;
	bit          hold_done = 1'b0;

	// Directed rows: reset key is 1, entries 0..63 preloaded as wildcards
	stim_row_t dir_rows [0:24] = '{
		'{OP_LOAD, 6'd0,  8'hA5, 1'b0, 8'h00, 1'b1, 7'd0,   1'b1, 1'b0, 32'd0},
		'{OP_SCAN, 6'd0,  8'h00, 1'b0, 8'hA5, 1'b0, 7'd0,   1'b1, 1'b1, 32'd0},
		'{OP_SCAN, 6'd0,  8'h00, 1'b0, 8'hA5, 1'b0, 7'd0,   1'b1, 1'b0, 32'd0},
		'{OP_SCAN, 6'd0,  8'h00, 1'b0, 8'hA5, 1'b0, 7'd0,   1'b1, 1'b1, 32'd2},
		'{OP_SCAN, 6'd0,  8'h00, 1'b0, 8'h5A, 1'b1, 7'd0,   1'b1, 1'b0, 32'd0},
		'{OP_SCAN, 6'd0,  8'h00, 1'b0, 8'hA5, 1'b1, 7'd0,   1'b1, 1'b1, 32'd0},
		'{OP_LOAD, 6'd0,  8'hFF, 1'b1, 8'h00, 1'b0, 7'd0,   1'b1, 1'b0, 32'd0},
		'{OP_SCAN, 6'd0,  8'h00, 1'b0, 8'h00, 1'b0, 7'd0,   1'b1, 1'b1, 32'd0},
		'{OP_SCAN, 6'd0,  8'h00, 1'b0, 8'hFF, 1'b0, 7'd0,   1'b1, 1'b0, 32'd0},
		'{OP_SCAN, 6'd0,  8'h00, 1'b0, 8'h00, 1'b1, 7'd0,   1'b1, 1'b1, 32'd2},
		'{OP_LOAD, 6'd1,  8'h00, 1'b0, 8'hFF, 1'b1, 7'd0,   1'b1, 1'b0, 32'd0},
		'{OP_LOAD, 6'd2,  8'hFF, 1'b0, 8'h00, 1'b0, 7'd0,   1'b1, 1'b0, 32'd0},
		'{OP_LOAD, 6'd63, 8'h80, 1'b1, 8'h00, 1'b0, 7'd0,   1'b1, 1'b0, 32'd0},
		'{OP_KEY,  6'd0,  8'h00, 1'b0, 8'h00, 1'b0, 7'd0,   1'b0, 1'b0, 32'd0},
		'{OP_SCAN, 6'd0,  8'h00, 1'b0, 8'h12, 1'b0, 7'd0,   1'b1, 1'b1, 32'd0},
		// key grows mid-region; the earlier match still blocks offset 0
		'{OP_KEY,  6'd0,  8'h00, 1'b0, 8'h00, 1'b0, 7'd3,   1'b0, 1'b0, 32'd0},
		'{OP_SCAN, 6'd0,  8'h00, 1'b0, 8'h00, 1'b0, 7'd0,   1'b1, 1'b0, 32'd0},
		'{OP_SCAN, 6'd0,  8'h00, 1'b0, 8'hFF, 1'b1, 7'd0,   1'b1, 1'b0, 32'd0},
		// match whose window ends on the region's final byte
		'{OP_SCAN, 6'd0,  8'h00, 1'b0, 8'h34, 1'b0, 7'd0,   1'b1, 1'b0, 32'd0},
		'{OP_SCAN, 6'd0,  8'h00, 1'b0, 8'h00, 1'b0, 7'd0,   1'b1, 1'b0, 32'd0},
		'{OP_SCAN, 6'd0,  8'h00, 1'b0, 8'hFF, 1'b1, 7'd0,   1'b1, 1'b1, 32'd0},
		// short window: zero fill would match but is never tested
		'{OP_SCAN, 6'd0,  8'h00, 1'b0, 8'h00, 1'b0, 7'd0,   1'b1, 1'b0, 32'd0},
		'{OP_SCAN, 6'd0,  8'h00, 1'b0, 8'hFF, 1'b1, 7'd0,   1'b1, 1'b0, 32'd0},
		'{OP_KEY,  6'd0,  8'h00, 1'b0, 8'h00, 1'b0, 7'd127, 1'b0, 1'b0, 32'd0},
		'{OP_SCAN, 6'd0,  8'h00, 1'b0, 8'h7E, 1'b1, 7'd0,   1'b1, 1'b0, 32'd0}
	};

	wildcard_byte_pattern_scanner_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.entry_index    (entry_index),
		.entry_value    (entry_value),
		.entry_wildcard (entry_wildcard),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.match_offset   (match_offset),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.key_length     (key_length)
	);

	always #1 clk = ~clk;

	// Push one byte into the window mirror and test for a match
	function automatic void advance_scan(input logic [7:0] b, input logic lastb,
		output logic hit, output logic [31:0] off);
		int          len;
		int          i;
		logic [32:0] pos1;
		logic [31:0] start;
		logic        ok;
		len = (mdl_key == 7'd0) ? 1 : ((mdl_key > 7'd64) ? 64 : int'(mdl_key));
		for (i = 63; i > 0; i--) mdl_win[i] = mdl_win[i-1];
		mdl_win[0] = b;
		hit = 1'b0;
		off = '0;
		pos1 = {1'b0, mdl_pos} + 33'd1;
		if (pos1 >= 33'(len)) begin
			start = 32'(pos1 - 33'(len));
			if ((pos1 - 33'(len)) >= {1'b0, mdl_next}) begin
				ok = 1'b1;
				for (i = 0; i < len; i++) begin
					if (!mdl_pat[i][8] && mdl_pat[i][7:0] != mdl_win[len-1-i]) ok = 1'b0;
				end
				if (ok) begin
					hit = 1'b1;
					off = start;
					mdl_next = start + 32'(len) + 32'd1;
				end
			end
		end
		if (lastb) begin
			mdl_pos = '0;
			mdl_next = '0;
			for (i = 0; i < 64; i++) mdl_win[i] = '0;
		end else begin
			mdl_pos = mdl_pos + 32'd1;
		end
	endfunction

	// Biased byte: mostly a small alphabet so random content lines up
	function automatic logic [7:0] pick_byte();
		logic [7:0] alpha [0:3];
		alpha = '{8'h00, 8'h5A, 8'hA5, 8'hFF};
		if ($urandom_range(99) < 70) return alpha[$urandom_range(3)];
		return 8'($urandom);
	endfunction

	function automatic logic [6:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 55) return 7'($urandom_range(4, 1));
		if (r < 75) return 7'($urandom_range(12, 5));
		if (r < 85) return 7'd64;
		if (r < 93) return 7'($urandom_range(127, 65));
		if (r < 97) return 7'd0;
		return 7'd127;
	endfunction

	// Stop input, wait out all pending matches plus scan latency
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (offsets_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Drive one step; a load or scan returns at the rising edge of its transfer
	task automatic drive_item(input stim_row_t r);
		logic        hit;
		logic [31:0] off;
		if (r.op == OP_KEY) begin
			settle();
			@(negedge clk);
			cfg_valid <= 1'b1;
			key_length <= r.key;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			mdl_key = r.key;
			@(negedge clk);
			cfg_valid <= 1'b0;
		end else begin
			@(negedge clk);
			while ($urandom_range(99) < send_idle_pct) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
			in_valid <= 1'b1;
			kind <= (r.op == OP_LOAD) ? wbps_pkg::KIND_LOAD : wbps_pkg::KIND_SCAN;
			entry_index <= r.idx;
			entry_value <= r.val;
			entry_wildcard <= r.wild;
			data_byte <= r.data;
			last_byte <= r.lastb;
			@(posedge clk);
			while (!in_ready) @(posedge clk);
			hit = 1'b0;
			off = '0;
			if (r.op == OP_LOAD) mdl_pat[r.idx] = {r.wild, r.val};
			else advance_scan(r.data, r.lastb, hit, off);
			if (r.typed) begin
				hit = r.t_hit;
				off = r.t_off;
			end
			if (hit) offsets_due = {offsets_due, off};
		end
	endtask

	task automatic send_load(input logic [5:0] idx, input logic [7:0] val, input logic wild);
		items_sent++;
		drive_item('{OP_LOAD, idx, val, wild, 8'($urandom), 1'($urandom), 7'd0,
			1'b0, 1'b0, 32'd0});
	endtask

	task automatic send_scan(input logic [7:0] b, input logic lastb);
		items_sent++;
		drive_item('{OP_SCAN, 6'($urandom), 8'($urandom), 1'($urandom), b, lastb, 7'd0,
			1'b0, 1'b0, 32'd0});
	endtask

	task automatic write_key(input logic [6:0] kv);
		drive_item('{OP_KEY, 6'd0, 8'h00, 1'b0, 8'h00, 1'b0, kv, 1'b0, 1'b0, 32'd0});
	endtask

	// Key setting, fresh pattern, then mostly embedded copies of the pattern
	task automatic run_random_phase(input int count);
		int         stop_at;
		int         budget;
		int         len;
		int         r;
		int         k;
		int         flip;
		logic [6:0] kv;
		logic [7:0] b;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			kv = pick_key();
			write_key(kv);
			len = (kv == 7'd0) ? 1 : ((kv > 7'd64) ? 64 : int'(kv));
			for (k = 0; k < len; k++) send_load(6'(k), pick_byte(), $urandom_range(99) < 35);
			budget = items_sent + ((len > 16) ? 2 * len + 20 : 50);
			while (items_sent < budget) begin
				r = $urandom_range(99);
				if (r < 55) begin
					// a broken copy gets one bit flipped
					flip = (r >= 45) ? $urandom_range(len - 1) : -1;
					for (k = 0; k < len; k++) begin
						b = mdl_pat[k][8] ? 8'($urandom) : mdl_pat[k][7:0];
						if (k == flip) b = b ^ 8'(1 << $urandom_range(7));
						send_scan(b, (k == len - 1) && ($urandom_range(99) < 15));
					end
				end else if (r < 60) begin
					send_load(6'($urandom_range(63)), pick_byte(), $urandom_range(99) < 35);
				end else if (r < 63) begin
					send_scan(pick_byte(), 1'b1);
				end else begin
					repeat ($urandom_range(6, 1)) send_scan(pick_byte(), 1'b0);
				end
			end
		end
	endtask

	// Result side readiness, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Compare each result transfer with the oldest expected offset
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (offsets_due.size() == 0) begin
				errors++;
				$display("%0t: match_offset expected none, actual %0d", $time, match_offset);
			end else begin
				want = offsets_due.pop_front();
				if (match_offset !== want) begin
					errors++;
					$display("%0t: match_offset expected %0d, actual %0d",
						$time, want, match_offset);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_wildcard_byte_pattern_scanner_unit: done, errors");
			$finish;
		end
	end

	initial begin
		int i;
		int send_mode [0:3];
		int recv_mode [0:3];
		send_mode = '{0, 63, 0, 8};
		recv_mode = '{0, 0, 63, 8};
		for (i = 0; i < 64; i++) begin
			mdl_pat[i] = '0;
			mdl_win[i] = '0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// every entry is written before any scan can read it
		for (i = 0; i < 64; i++) send_load(6'(i), 8'($urandom), 1'b1);
		for (i = 0; i < 25; i++) drive_item(dir_rows[i]);

		for (i = 0; i < 4; i++) begin
			send_idle_pct = send_mode[i];
			recv_stall_pct = recv_mode[i];
			run_random_phase(140);
		end

		// back-pressure: every other byte matches while results are held off
		settle();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_key(7'd1);
		send_load(6'd0, 8'h00, 1'b1);
		hold_req = 1'b1;
		repeat (40) send_scan(8'($urandom), 1'b0);
		send_scan(8'($urandom), 1'b1);
		settle();

		if (errors == 0) begin
			$display("tb_wildcard_byte_pattern_scanner_unit: done, clean");
		end else begin
			$display("tb_wildcard_byte_pattern_scanner_unit: done, errors");
		end
		$finish;
	end

endmodule
